/* hw/rtl/tts_pkg.sv */
// Shared types and constants for the text terminal screen buffer.
package tts_pkg;

  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 32;
  localparam int STORE_SIZE = MAX_COLS * MAX_ROWS;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int WID_W      = COL_W + 1;
  localparam int HGT_W      = ROW_W + 1;

  localparam logic [31:0] BLANK_CELL = 32'h0000_0720;

  localparam logic [7:0] COLUMNS_RST = 8'd80;
  localparam logic [5:0] ROWS_RST    = 6'd25;

  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;

  localparam logic [3:0] KIND_PUT   = 4'd0;
  localparam logic [3:0] KIND_CR    = 4'd1;
  localparam logic [3:0] KIND_LF    = 4'd2;
  localparam logic [3:0] KIND_BS    = 4'd3;
  localparam logic [3:0] KIND_MOVE  = 4'd5;
  localparam logic [3:0] KIND_POS   = 4'd6;
  localparam logic [3:0] KIND_ERASE = 4'd7;
  localparam logic [3:0] KIND_CLEAR = 4'd8;
  localparam logic [3:0] KIND_READ  = 4'd9;

  localparam logic [7:0] ERASE_TO_END   = 8'd0;
  localparam logic [7:0] ERASE_TO_START = 8'd1;
  localparam logic [7:0] ERASE_ALL      = 8'd2;

  typedef struct packed {
    logic [3:0]         kind;
    logic [7:0]         ch;
    logic [7:0]         fg;
    logic [7:0]         bg;
    logic [7:0]         flags;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [15:0]        row;
    logic [15:0]        col;
    logic [7:0]         erase_mode;
    logic [6:0]         read_col;
    logic [4:0]         read_row;
  } in_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_ch;
    logic [7:0] cell_fg;
    logic [7:0] cell_bg;
    logic [7:0] cell_flags;
  } out_t;

  typedef enum logic [3:0] {
    OP_PUT, OP_CR, OP_LF, OP_BS, OP_MOVE, OP_POS,
    OP_ERASE_END, OP_ERASE_START, OP_CLEAR, OP_READ, OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [31:0]        put_data;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [15:0]        row;
    logic [15:0]        col;
    logic [COL_W-1:0]   read_col;
    logic [ROW_W-1:0]   read_row;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_q_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CALC, ST_EXEC, ST_SCROLL, ST_SCR_WR, ST_BLANK, ST_RD_WAIT, ST_DONE
  } bk_state_t;

endpackage

/* hw/rtl/tts_front.sv */
// Command front end: accepts items, classifies them and queues them.
module tts_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  tts_pkg::in_t    in_item,
  input  logic            clearing,
  input  logic            pop,
  output logic            busy,
  output tts_pkg::cmd_q_t q_out
);

  tts_pkg::cmd_t fifo_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          push;
  tts_pkg::cmd_t cmd;

  assign busy = clearing | (cnt_r == 2'd2);
  assign push = start & ~busy;

  always_comb begin
    cmd.put_data = {in_item.flags, in_item.bg, in_item.fg, in_item.ch};
    cmd.dx       = in_item.dx;
    cmd.dy       = in_item.dy;
    cmd.row      = in_item.row;
    cmd.col      = in_item.col;
    cmd.read_col = in_item.read_col;
    cmd.read_row = in_item.read_row;
    unique case (in_item.kind)
      tts_pkg::KIND_PUT:   cmd.op = tts_pkg::OP_PUT;
      tts_pkg::KIND_CR:    cmd.op = tts_pkg::OP_CR;
      tts_pkg::KIND_LF:    cmd.op = tts_pkg::OP_LF;
      tts_pkg::KIND_BS:    cmd.op = tts_pkg::OP_BS;
      tts_pkg::KIND_MOVE:  cmd.op = tts_pkg::OP_MOVE;
      tts_pkg::KIND_POS:   cmd.op = tts_pkg::OP_POS;
      tts_pkg::KIND_CLEAR: cmd.op = tts_pkg::OP_CLEAR;
      tts_pkg::KIND_READ:  cmd.op = tts_pkg::OP_READ;
      tts_pkg::KIND_ERASE: begin
        unique case (in_item.erase_mode)
          tts_pkg::ERASE_TO_END:   cmd.op = tts_pkg::OP_ERASE_END;
          tts_pkg::ERASE_TO_START: cmd.op = tts_pkg::OP_ERASE_START;
          tts_pkg::ERASE_ALL:      cmd.op = tts_pkg::OP_CLEAR; // same as clear
          default:                 cmd.op = tts_pkg::OP_NOP;
        endcase
      end
      default: cmd.op = tts_pkg::OP_NOP; // bell and unused kinds
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign q_out.valid = (cnt_r != 2'd0);
  assign q_out.cmd   = fifo_r[rd_ptr_r];

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("pop from empty queue");

endmodule

/* hw/rtl/tts_back.sv */
// Command executor: cursor, cell memory, scroll and erase sweeps.
module tts_back (
  input  logic            clk,
  input  logic            rst_n,
  input  tts_pkg::cmd_q_t q_in,
  input  logic [7:0]      width,
  input  logic [5:0]      height,
  output logic            pop,
  output logic            clearing,
  output logic            out_valid,
  output tts_pkg::out_t   out_item
);

  localparam int CW = tts_pkg::COL_W;
  localparam int RW = tts_pkg::ROW_W;
  localparam int AW = tts_pkg::ADDR_W;
  localparam int NW = tts_pkg::CNT_W;

  logic [31:0] mem [tts_pkg::STORE_SIZE];
  logic [31:0] rdata_r;
  logic        we, re;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;

  tts_pkg::bk_state_t state_r, state_nxt;
  tts_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [NW-1:0] lin_r, lin_nxt, n_r, n_nxt, idx_r, idx_nxt, end_r, end_nxt;
  logic [31:0]   cell_r, cell_nxt;
  logic          init_r, init_nxt;

  logic [CW-1:0] csel;
  logic [RW-1:0] rsel;
  logic [NW-1:0] w_n;
  logic          on_screen, rd_hit;

  function automatic logic [7:0] clamp_add(logic [7:0] base, logic signed [15:0] d,
                                           logic [7:0] lim);
    logic signed [17:0] v;
    v = $signed({10'd0, base}) + $signed({{2{d[15]}}, d});
    if (v < 18'sd0) v = 18'sd0;
    if (v >= $signed({10'd0, lim})) v = $signed({10'd0, lim}) - 18'sd1;
    return v[7:0];
  endfunction

  function automatic logic [7:0] pos_clamp(logic [15:0] v, logic [7:0] lim);
    logic [15:0] r;
    r = (v == 16'd0) ? 16'd1 : v;
    if (r > {8'd0, lim}) r = {8'd0, lim};
    return 8'(r - 16'd1);
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign w_n       = NW'(width);
  assign on_screen = ({1'b0, col_r} < width) && ({1'b0, row_r} < height);
  assign rd_hit    = ({1'b0, cmd_r.read_col} < width) && ({1'b0, cmd_r.read_row} < height);
  assign csel      = (cmd_r.op == tts_pkg::OP_READ) ? cmd_r.read_col : col_r;
  assign rsel      = (cmd_r.op == tts_pkg::OP_READ) ? cmd_r.read_row : row_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    lin_nxt   = lin_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    end_nxt   = end_r;
    cell_nxt  = cell_r;
    init_nxt  = init_r;
    pop       = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = idx_r[AW-1:0];
    raddr     = lin_r[AW-1:0];
    wdata     = tts_pkg::BLANK_CELL;
    out_valid = 1'b0;
    unique case (state_r)
      tts_pkg::ST_IDLE: begin
        if (q_in.valid) begin
          pop       = 1'b1;
          cmd_nxt   = q_in.cmd;
          state_nxt = tts_pkg::ST_CALC;
        end
      end
      tts_pkg::ST_CALC: begin
        lin_nxt   = NW'({{(NW-RW){1'b0}}, rsel} * w_n + {{(NW-CW){1'b0}}, csel});
        n_nxt     = NW'(w_n * NW'(height));
        cell_nxt  = '0;
        state_nxt = tts_pkg::ST_EXEC;
      end
      tts_pkg::ST_EXEC: begin
        state_nxt = tts_pkg::ST_DONE;
        unique case (cmd_r.op)
          tts_pkg::OP_PUT: begin
            if (on_screen) begin
              we    = 1'b1;
              waddr = lin_r[AW-1:0];
              wdata = cmd_r.put_data;
              if (({1'b0, col_r} + 8'd1) >= width) begin
                col_nxt = '0;
                if (({1'b0, row_r} + 6'd1) < height) begin
                  row_nxt = row_r + 1'b1;
                end else begin
                  row_nxt   = RW'(height - 6'd1);
                  idx_nxt   = '0;
                  state_nxt = tts_pkg::ST_SCROLL;
                end
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
          end
          tts_pkg::OP_CR: col_nxt = '0;
          tts_pkg::OP_LF: begin
            if (({1'b0, row_r} + 6'd1) < height) begin
              row_nxt = row_r + 1'b1;
            end else begin
              idx_nxt   = '0;
              state_nxt = tts_pkg::ST_SCROLL;
            end
          end
          tts_pkg::OP_BS: begin
            if (col_r != '0) col_nxt = col_r - 1'b1;
          end
          tts_pkg::OP_MOVE: begin
            col_nxt = CW'(clamp_add({1'b0, col_r}, cmd_r.dx, width));
            row_nxt = RW'(clamp_add({3'd0, row_r}, cmd_r.dy, {2'd0, height}));
          end
          tts_pkg::OP_POS: begin
            col_nxt = CW'(pos_clamp(cmd_r.col, width));
            row_nxt = RW'(pos_clamp(cmd_r.row, {2'd0, height}));
          end
          tts_pkg::OP_ERASE_END: begin
            idx_nxt   = lin_r;
            end_nxt   = n_r;
            state_nxt = tts_pkg::ST_BLANK;
          end
          tts_pkg::OP_ERASE_START: begin
            idx_nxt   = '0;
            end_nxt   = ((lin_r + 1'b1) < n_r) ? lin_r + 1'b1 : n_r;
            state_nxt = tts_pkg::ST_BLANK;
          end
          tts_pkg::OP_CLEAR: begin
            idx_nxt   = '0;
            end_nxt   = n_r;
            col_nxt   = '0;
            row_nxt   = '0;
            state_nxt = tts_pkg::ST_BLANK;
          end
          tts_pkg::OP_READ: begin
            if (rd_hit) begin
              re        = 1'b1;
              state_nxt = tts_pkg::ST_RD_WAIT;
            end
          end
          default: ;
        endcase
      end
      tts_pkg::ST_SCROLL: begin
        if ((idx_r + w_n) < n_r) begin
          re        = 1'b1;
          raddr     = AW'(idx_r + w_n);
          state_nxt = tts_pkg::ST_SCR_WR;
        end else begin
          end_nxt   = n_r;
          state_nxt = tts_pkg::ST_BLANK;
        end
      end
      tts_pkg::ST_SCR_WR: begin
        we        = 1'b1;
        wdata     = rdata_r;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = tts_pkg::ST_SCROLL;
      end
      tts_pkg::ST_BLANK: begin
        if (idx_r < end_r) begin
          we      = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else begin
          init_nxt  = 1'b0;
          state_nxt = init_r ? tts_pkg::ST_IDLE : tts_pkg::ST_DONE;
        end
      end
      tts_pkg::ST_RD_WAIT: begin
        cell_nxt  = rdata_r;
        state_nxt = tts_pkg::ST_DONE;
      end
      tts_pkg::ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = tts_pkg::ST_IDLE;
      end
      default: state_nxt = tts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tts_pkg::ST_BLANK;
      col_r   <= '0;
      row_r   <= '0;
      idx_r   <= '0;
      end_r   <= NW'(tts_pkg::STORE_SIZE);
      init_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      idx_r   <= idx_nxt;
      end_r   <= end_nxt;
      init_r  <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    lin_r  <= lin_nxt;
    n_r    <= n_nxt;
    cell_r <= cell_nxt;
  end

  assign clearing            = init_r;
  assign out_item.cursor_col = col_r;
  assign out_item.cursor_row = row_r;
  assign out_item.cell_ch    = cell_r[7:0];
  assign out_item.cell_fg    = cell_r[15:8];
  assign out_item.cell_bg    = cell_r[23:16];
  assign out_item.cell_flags = cell_r[31:24];

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !out_valid) else $error("result during clearing pass");

  a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cmd_r.op == tts_pkg::OP_CLEAR |-> col_r == '0 && row_r == '0)
    else $error("clear left cursor off home");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tts_pkg::ST_IDLE |-> !we) else $error("memory write while idle");

endmodule

/* hw/rtl/text_terminal_screen_buffer.sv */
// Top level of the text terminal screen buffer: config registers and the two halves.
// Each item passes through the calc, exec and done states; a read adds a memory wait state,
// erase and clear sweep the cells they blank, and a scroll copies the screen up a row first.
// The executor works on one item at a time; a two-entry queue lets start be taken meanwhile.
// Reset: a clearing pass blanks the whole store, busy stays high meanwhile.
// The receiver cannot stall: each result shows for exactly one cycle on out_valid.
module text_terminal_screen_buffer (
  input  logic          clk,
  input  logic          rst_n,
  // item channel
  input  logic          start,
  output logic          busy,
  input  tts_pkg::in_t  in_item,
  // result channel
  output logic          out_valid,
  output tts_pkg::out_t out_item,
  // configuration
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data
);

  logic [7:0] columns_r;
  logic [5:0] rows_r;
  logic [7:0] width;
  logic [5:0] height;
  logic       pop, clearing;
  tts_pkg::cmd_q_t q;

  // Register writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= tts_pkg::COLUMNS_RST;
      rows_r    <= tts_pkg::ROWS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tts_pkg::CFG_COLUMNS: columns_r <= cfg_data;
        tts_pkg::CFG_ROWS:    rows_r    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Effective screen size, limited to 1..max in each direction.
  always_comb begin
    width = columns_r;
    if (columns_r == 8'd0) width = 8'd1;
    else if (columns_r > 8'(tts_pkg::MAX_COLS)) width = 8'(tts_pkg::MAX_COLS);
    height = rows_r;
    if (rows_r == 6'd0) height = 6'd1;
    else if (rows_r > 6'(tts_pkg::MAX_ROWS)) height = 6'(tts_pkg::MAX_ROWS);
  end

  // Front end decodes each item and holds up to two in its queue.
  tts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .clearing (clearing),
    .pop      (pop),
    .busy     (busy),
    .q_out    (q)
  );

  // Executor owns the cursor and the cell memory.
  tts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_in      (q),
    .width     (width),
    .height    (height),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the text terminal screen buffer.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes the package leaves out
  localparam logic [3:0] KIND_BELL       = 4'd4;
  localparam logic [3:0] KIND_SPARE      = 4'd10; // 10..15 do nothing
  localparam logic [3:0] KIND_SPARE_LAST = 4'd15;
  localparam logic [7:0] CH_SPACE        = 8'h20;
  localparam logic [7:0] FG_DEFAULT      = 8'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  tts_pkg::in_t  in_item = '0;
  logic out_valid;
  tts_pkg::out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = tts_pkg::CFG_COLUMNS;
  logic [7:0] cfg_data = '0;

  text_terminal_screen_buffer u_top (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Timeout: generous for the clearing pass and full-screen scrolls
  initial begin
    #100ms;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Screen model: own copy of cells, cursor and size registers
  // ---------------------------------------------------------------------------
  logic [31:0]   screen [tts_pkg::STORE_SIZE];
  int unsigned   cur_x, cur_y;
  logic [7:0]    width_reg;
  logic [5:0]    height_reg;
  tts_pkg::out_t expected_q [$];
  int            errors = 0;

  function automatic int unsigned act_w();
    if (width_reg == 0) return 1;
    return (width_reg > tts_pkg::MAX_COLS) ? tts_pkg::MAX_COLS : width_reg;
  endfunction

  function automatic int unsigned act_h();
    if (height_reg == 0) return 1;
    return (height_reg > tts_pkg::MAX_ROWS) ? tts_pkg::MAX_ROWS : height_reg;
  endfunction

  function automatic void blank_cells(int unsigned from, int unsigned upto);
    for (int unsigned i = from; i < upto && i < tts_pkg::STORE_SIZE; i++)
      screen[i] = tts_pkg::BLANK_CELL;
  endfunction

  function automatic void scroll_screen();
    int unsigned w, n, i;
    w = act_w();
    n = w * act_h();
    for (i = 0; i + w < n; i++) screen[i] = screen[i + w];
    blank_cells(i, n);
  endfunction

  function automatic int unsigned clamp_to(int unsigned base, int d, int unsigned lim);
    int v;
    v = int'(base) + d;
    if (v < 0) v = 0;
    if (v >= int'(lim)) v = int'(lim) - 1;
    return unsigned'(v);
  endfunction

  // Applies one command and returns the result it should produce
  function automatic tts_pkg::out_t screen_step(tts_pkg::in_t it);
    int unsigned w, h, n, r, c, lin;
    logic [31:0] rd_cell;
    tts_pkg::out_t res;
    w = act_w();
    h = act_h();
    n = w * h;
    rd_cell = '0;
    case (it.kind)
      tts_pkg::KIND_PUT: begin
        if (cur_x < w && cur_y < h) begin
          screen[cur_y * w + cur_x] = {it.flags, it.bg, it.fg, it.ch};
          cur_x++;
          if (cur_x >= w) begin
            cur_x = 0;
            if (cur_y + 1 < h) cur_y++;
            else begin
              scroll_screen();
              cur_y = h - 1;
            end
          end
        end
      end
      tts_pkg::KIND_CR: cur_x = 0;
      tts_pkg::KIND_LF: begin
        if (cur_y + 1 < h) cur_y++;
        else scroll_screen();
      end
      tts_pkg::KIND_BS: if (cur_x > 0) cur_x--;
      tts_pkg::KIND_MOVE: begin
        cur_x = clamp_to(cur_x, int'(it.dx), w);
        cur_y = clamp_to(cur_y, int'(it.dy), h);
      end
      tts_pkg::KIND_POS: begin
        r = (it.row == 0) ? 1 : it.row;
        c = (it.col == 0) ? 1 : it.col;
        if (r > h) r = h;
        if (c > w) c = w;
        cur_y = r - 1;
        cur_x = c - 1;
      end
      tts_pkg::KIND_ERASE: begin
        lin = cur_y * w + cur_x;
        if (it.erase_mode == tts_pkg::ERASE_TO_END) blank_cells(lin, n);
        else if (it.erase_mode == tts_pkg::ERASE_TO_START)
          blank_cells(0, (lin + 1 < n) ? lin + 1 : n);
        else if (it.erase_mode == tts_pkg::ERASE_ALL) begin
          blank_cells(0, n);
          cur_x = 0;
          cur_y = 0;
        end
      end
      tts_pkg::KIND_CLEAR: begin
        blank_cells(0, n);
        cur_x = 0;
        cur_y = 0;
      end
      tts_pkg::KIND_READ:
        if (it.read_col < w && it.read_row < h) rd_cell = screen[it.read_row * w + it.read_col];
      default: ;
    endcase
    res.cursor_col = cur_x[6:0];
    res.cursor_row = cur_y[4:0];
    {res.cell_flags, res.cell_bg, res.cell_fg, res.cell_ch} = rd_cell;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check results, predict on acceptance
  // ---------------------------------------------------------------------------
  logic typed_valid = 1'b0; // row carries a hand-typed expectation
  tts_pkg::out_t typed_res = '0;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    tts_pkg::out_t want, pred;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_q.size() == 0) report_mismatch("unexpected item", 1, 0);
        else begin
          want = expected_q.pop_front();
          if (out_item.cursor_col != want.cursor_col)
            report_mismatch("cursor_col", out_item.cursor_col, want.cursor_col);
          if (out_item.cursor_row != want.cursor_row)
            report_mismatch("cursor_row", out_item.cursor_row, want.cursor_row);
          if (out_item.cell_ch != want.cell_ch)
            report_mismatch("cell_ch", out_item.cell_ch, want.cell_ch);
          if (out_item.cell_fg != want.cell_fg)
            report_mismatch("cell_fg", out_item.cell_fg, want.cell_fg);
          if (out_item.cell_bg != want.cell_bg)
            report_mismatch("cell_bg", out_item.cell_bg, want.cell_bg);
          if (out_item.cell_flags != want.cell_flags)
            report_mismatch("cell_flags", out_item.cell_flags, want.cell_flags);
        end
      end
      if (start && !busy) begin
        pred = screen_step(in_item);
        expected_q.push_back(typed_valid ? typed_res : pred);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tts_pkg::CFG_COLUMNS) width_reg = cfg_data;
        else if (cfg_index == tts_pkg::CFG_ROWS) height_reg = cfg_data[5:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  bit no_gaps;

  // Mostly back to back, some short gaps, a few long ones
  task automatic idle_gap();
    int unsigned p, g;
    p = $urandom_range(0, 99);
    g = no_gaps ? 0 : (p < 60) ? 0 : (p < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (g != 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Holds start high until the item is taken
  task automatic send_item(tts_pkg::in_t it, bit typed, tts_pkg::out_t res);
    start       <= 1'b1;
    in_item     <= it;
    typed_valid <= typed;
    typed_res   <= res;
    do @(posedge clk); while (busy);
    idle_gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk); // margin before the next size change
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Well-formed commands with random content, plus some noise
  function automatic tts_pkg::in_t random_cmd();
    tts_pkg::in_t it;
    int unsigned p, w, h;
    w = act_w();
    h = act_h();
    it.kind = tts_pkg::KIND_PUT;
    it.ch = 8'($urandom); it.fg = 8'($urandom); it.bg = 8'($urandom);
    it.flags = 8'($urandom);
    it.dx = 16'($urandom); it.dy = 16'($urandom);
    it.row = 16'($urandom); it.col = 16'($urandom);
    it.erase_mode = 8'($urandom); it.read_col = 7'($urandom); it.read_row = 5'($urandom);
    p = $urandom_range(0, 99);
    if (p < 42) it.kind = tts_pkg::KIND_PUT;
    else if (p < 47) it.kind = tts_pkg::KIND_CR;
    else if (p < 54) it.kind = tts_pkg::KIND_LF;
    else if (p < 59) it.kind = tts_pkg::KIND_BS;
    else if (p < 61) it.kind = KIND_BELL;
    else if (p < 67) begin
      it.kind = tts_pkg::KIND_MOVE;
      if ($urandom_range(0, 3) != 0) begin
        it.dx = 16'($signed($urandom_range(0, 2 * w)) - int'(w));
        it.dy = 16'($signed($urandom_range(0, 2 * h)) - int'(h));
      end
    end else if (p < 75) begin
      it.kind = tts_pkg::KIND_POS;
      if ($urandom_range(0, 4) != 0) begin
        it.row = 16'($urandom_range(0, h + 1));
        it.col = 16'($urandom_range(0, w + 1));
      end
    end else if (p < 80) begin
      it.kind = tts_pkg::KIND_ERASE;
      if ($urandom_range(0, 4) != 0) it.erase_mode = 8'($urandom_range(0, 3));
    end else if (p < 82) it.kind = tts_pkg::KIND_CLEAR;
    else if (p < 97) begin
      it.kind = tts_pkg::KIND_READ;
      if ($urandom_range(0, 4) != 0) begin
        it.read_col = 7'($urandom_range(0, w - 1));
        it.read_row = 5'($urandom_range(0, h - 1));
      end
    end else it.kind = 4'($urandom_range(KIND_SPARE, KIND_SPARE_LAST));
    return it;
  endfunction

  function automatic tts_pkg::in_t cmd(logic [3:0] k, logic [7:0] a, logic [7:0] b,
                                       logic [7:0] c, logic [7:0] d, logic [15:0] x,
                                       logic [15:0] y);
    tts_pkg::in_t it;
    it = '0;
    it.kind = k;
    it.ch = a; it.fg = b; it.bg = c; it.flags = d;
    it.dx = x; it.dy = y; it.row = x; it.col = y;
    it.erase_mode = a; it.read_col = x[6:0]; it.read_row = y[4:0];
    return it;
  endfunction

  function automatic tts_pkg::out_t res_of(int x, int y, logic [7:0] ch, logic [7:0] fg,
                                           logic [7:0] bg, logic [7:0] fl);
    tts_pkg::out_t r;
    r.cursor_col = 7'(x); r.cursor_row = 5'(y);
    r.cell_ch = ch; r.cell_fg = fg; r.cell_bg = bg; r.cell_flags = fl;
    return r;
  endfunction

  // Directed rows, run at the reset size of 80 x 25
  typedef struct {
    tts_pkg::in_t  it;
    bit            typed;
    tts_pkg::out_t res;
  } row_t;

  row_t dir_rows [$];

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned cnt;
    logic [7:0] wset [8];
    logic [5:0] hset [8];
    int unsigned nset [8];

    blank_cells(0, tts_pkg::STORE_SIZE);
    cur_x = 0;
    cur_y = 0;
    width_reg = tts_pkg::COLUMNS_RST;
    height_reg = tts_pkg::ROWS_RST;

    // Blank read after reset, put and read back, backspace at both ends
    dir_rows.push_back('{cmd(tts_pkg::KIND_READ, 0, 0, 0, 0, 0, 0), 1,
                         res_of(0, 0, CH_SPACE, FG_DEFAULT, 0, 0)});
    dir_rows.push_back('{cmd(tts_pkg::KIND_PUT, "A", 1, 2, 8'h80, 0, 0), 1,
                         res_of(1, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{cmd(tts_pkg::KIND_READ, 0, 0, 0, 0, 0, 0), 1,
                         res_of(1, 0, "A", 1, 2, 8'h80)});
    dir_rows.push_back('{cmd(tts_pkg::KIND_BS, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{cmd(tts_pkg::KIND_BS, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, 0, 0, 0, 0)});
    // Position clamp to bottom right, then a put that wraps and scrolls
    dir_rows.push_back('{cmd(tts_pkg::KIND_POS, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF), 1,
                         res_of(79, 24, 0, 0, 0, 0)});
    dir_rows.push_back('{cmd(tts_pkg::KIND_PUT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 0), 1,
                         res_of(0, 24, 0, 0, 0, 0)});
    dir_rows.push_back('{cmd(tts_pkg::KIND_READ, 0, 0, 0, 0, 79, 23), 1,
                         res_of(0, 24, 8'hFF, 8'hFF, 8'hFF, 8'hFF)});
    // Relative move at the extremes, clamped both ways
    dir_rows.push_back('{cmd(tts_pkg::KIND_MOVE, 0, 0, 0, 0, 16'h7FFF, 16'h8000), 1,
                         res_of(79, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{cmd(tts_pkg::KIND_MOVE, 0, 0, 0, 0, 16'h8000, 16'h7FFF), 1,
                         res_of(0, 24, 0, 0, 0, 0)});
    // Line feed on the last row scrolls and keeps the row
    dir_rows.push_back('{cmd(tts_pkg::KIND_LF, 0, 0, 0, 0, 0, 0), 1,
                         res_of(0, 24, 0, 0, 0, 0)});
    dir_rows.push_back('{cmd(tts_pkg::KIND_READ, 0, 0, 0, 0, 79, 22), 1,
                         res_of(0, 24, 8'hFF, 8'hFF, 8'hFF, 8'hFF)});
    // Bell, the last spare kind and an unknown erase mode leave everything alone
    dir_rows.push_back('{cmd(KIND_BELL, 0, 0, 0, 0, 0, 0), 1, res_of(0, 24, 0, 0, 0, 0)});
    dir_rows.push_back('{cmd(KIND_SPARE_LAST, 0, 0, 0, 0, 0, 0), 1,
                         res_of(0, 24, 0, 0, 0, 0)});
    dir_rows.push_back('{cmd(tts_pkg::KIND_ERASE, 8'hFF, 0, 0, 0, 0, 0), 1,
                         res_of(0, 24, 0, 0, 0, 0)});
    // Position 0 acts as 1; read outside the screen gives zero cells
    dir_rows.push_back('{cmd(tts_pkg::KIND_POS, 0, 0, 0, 0, 0, 0), 1,
                         res_of(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{cmd(tts_pkg::KIND_READ, 0, 0, 0, 0, 127, 31), 1,
                         res_of(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{cmd(tts_pkg::KIND_POS, 0, 0, 0, 0, 3, 5), 0, '0});
    dir_rows.push_back('{cmd(tts_pkg::KIND_ERASE, tts_pkg::ERASE_TO_END, 0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{cmd(tts_pkg::KIND_ERASE, tts_pkg::ERASE_TO_START, 0, 0, 0, 0, 0), 0,
                         '0});
    dir_rows.push_back('{cmd(tts_pkg::KIND_READ, 0, 0, 0, 0, 79, 22), 0, '0});
    dir_rows.push_back('{cmd(tts_pkg::KIND_ERASE, tts_pkg::ERASE_ALL, 0, 0, 0, 0, 0), 1,
                         res_of(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{cmd(tts_pkg::KIND_CR, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{cmd(tts_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0), 1,
                         res_of(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{cmd(tts_pkg::KIND_READ, 0, 0, 0, 0, 79, 24), 1,
                         res_of(0, 0, CH_SPACE, FG_DEFAULT, 0, 0)});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part; start waits out the clearing pass through busy
    no_gaps = 1'b0;
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
    drain();

    // Size settings: minimum, zero, oversized, maximum, then random small ones and the reset size.
    // Large screens get few items since scrolls and clears walk the whole store.
    wset = '{8'd1, 8'd0, 8'd255, 8'd128, 8'd7, 8'd3, 8'd16, 8'd80};
    hset = '{6'd1, 6'd0, 6'd63, 6'd32, 6'd4, 6'd9, 6'd2, 6'd25};
    nset = '{120, 120, 30, 30, 250, 250, 250, 150};
    for (int s = 0; s < 8; s++) begin
      if (s >= 4 && s < 7) begin
        wset[s] = 8'($urandom_range(1, 20));
        hset[s] = 6'($urandom_range(1, 8));
      end
      write_reg(tts_pkg::CFG_COLUMNS, wset[s]);
      write_reg(tts_pkg::CFG_ROWS, hset[s]);
      // Half the time no clear: the cursor may sit off the new screen
      if (s[0]) send_item(cmd(tts_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0), 0, '0);
      no_gaps = (s == 5);
      for (cnt = 0; cnt < nset[s]; cnt++) send_item(random_cmd(), 0, '0);
      drain();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
